// ===== src/char_lcd_command_sequencer_assert.svh =====
// assertion helpers for the lcd command sequencer
`ifndef CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH

// same-cycle implication, held off during reset
`define LCDSEQ_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define LCDSEQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lcdseq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcdseq_pkg;

    typedef enum logic [2:0] {
        OP_INIT        = 3'd0,
        OP_CLEAR       = 3'd1,
        OP_SET_CURSOR  = 3'd2,
        OP_WRITE_DATA  = 3'd3,
        OP_LOAD_GLYPH  = 3'd4
    } opcode_t;

    localparam int GLYPH_ROWS  = 8;
    localparam int GLYPH_SLOTS = 8;
    localparam int PIXEL_W     = 5;
    localparam int STEP_W      = 4;
    localparam int INIT_LEN    = 8;

    localparam logic [STEP_W-1:0] STEP_FIRST      = '0;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP  = STEP_W'(INIT_LEN - 1);
    localparam logic [STEP_W-1:0] GLYPH_LAST_STEP = STEP_W'(GLYPH_ROWS + 1);

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_LINE1_BASE   = 8'h80;
    localparam logic [7:0] CMD_LINE2_BASE   = 8'hC0;
    localparam logic [7:0] CMD_CGRAM_BASE   = 8'h40;

    localparam logic [1:0] ROW_LINE1 = 2'd1;
    localparam logic [1:0] ROW_LINE2 = 2'd2;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    typedef struct packed {
        logic [2:0]                     opcode;
        logic [5:0]                     column;
        logic [1:0]                     row;
        logic [7:0]                     char_code;
        logic [3:0]                     glyph_index;
        logic [GLYPH_ROWS*PIXEL_W-1:0]  glyph_bitmap;
    } item_t;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_byte;
        logic [3:0] wait_before_ms;
        logic [2:0] wait_after_ms;
        logic       write_valid;
        logic       last;
    } result_t;

    function automatic result_t init_write(input logic [2:0] idx);
        result_t r;
        r = '0;
        r.reg_select    = RS_COMMAND;
        r.write_valid   = 1'b1;
        r.wait_after_ms = 3'd1;
        unique case (idx)
            3'd0: begin
                r.bus_byte       = CMD_FUNCTION_SET;
                r.wait_before_ms = 4'd15;
                r.wait_after_ms  = 3'd5;
            end
            3'd1, 3'd2, 3'd3: r.bus_byte = CMD_FUNCTION_SET;
            3'd4: r.bus_byte = CMD_DISPLAY_OFF;
            3'd5: begin
                r.bus_byte      = CMD_CLEAR;
                r.wait_after_ms = 3'd2;
            end
            3'd6: r.bus_byte = CMD_ENTRY_MODE;
            default: r.bus_byte = CMD_DISPLAY_ON;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lcdseq_expand.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_expand (
    input  lcdseq_pkg::item_t               item,
    input  logic [lcdseq_pkg::STEP_W-1:0]   step,
    output lcdseq_pkg::result_t             res
);
    import lcdseq_pkg::*;

    logic [PIXEL_W-1:0] glyph_rows [GLYPH_ROWS];
    logic [STEP_W-1:0]  step_m1;
    result_t            rejected;

    always_comb begin
        for (int i = 0; i < GLYPH_ROWS; i++) begin
            glyph_rows[i] = item.glyph_bitmap[i*PIXEL_W +: PIXEL_W];
        end
    end

    assign step_m1 = step - STEP_W'(1);

    always_comb begin
        rejected      = '0;
        rejected.last = 1'b1;
    end

    always_comb begin
        res = rejected;
        unique case (opcode_t'(item.opcode))
            OP_INIT: begin
                res      = init_write(step[2:0]);
                res.last = (step == INIT_LAST_STEP);
            end
            OP_CLEAR: begin
                res               = '0;
                res.bus_byte      = CMD_CLEAR;
                res.wait_after_ms = 3'd2;
                res.write_valid   = 1'b1;
                res.last          = 1'b1;
            end
            OP_SET_CURSOR: begin
                if (item.row == ROW_LINE1 || item.row == ROW_LINE2) begin
                    res             = '0;
                    res.write_valid = 1'b1;
                    res.last        = 1'b1;
                    res.bus_byte    = ((item.row == ROW_LINE1) ? CMD_LINE1_BASE
                                                               : CMD_LINE2_BASE)
                                      + {2'b00, item.column};
                end
            end
            OP_WRITE_DATA: begin
                res             = '0;
                res.reg_select  = RS_DATA;
                res.bus_byte    = item.char_code;
                res.write_valid = 1'b1;
                res.last        = 1'b1;
            end
            OP_LOAD_GLYPH: begin
                if (item.glyph_index < 4'(GLYPH_SLOTS)) begin
                    res             = '0;
                    res.write_valid = 1'b1;
                    priority if (step == STEP_FIRST) begin
                        res.bus_byte = CMD_CGRAM_BASE | {2'b00, item.glyph_index[2:0], 3'b000};
                    end else if (step == GLYPH_LAST_STEP) begin
                        res.bus_byte = CMD_LINE1_BASE;
                        res.last     = 1'b1;
                    end else begin
                        res.reg_select = RS_DATA;
                        res.bus_byte   = {3'b000, glyph_rows[step_m1[2:0]]};
                    end
                end
            end
            default: res = rejected;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/lcdseq_item_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_item_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  lcdseq_pkg::item_t               s_item,
    input  logic                            advance,
    input  logic                            step_last,
    output lcdseq_pkg::item_t               item,
    output logic [lcdseq_pkg::STEP_W-1:0]   step,
    output logic                            busy
);
    import lcdseq_pkg::*;

    item_t             item_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              take;
    logic              done;

    assign done     = advance && step_last;
    assign s_tready = !busy_reg || done;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        priority if (take) begin
            busy_next = 1'b1;
            step_next = STEP_FIRST;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (advance) begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= STEP_FIRST;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
        end
    end

    assign item = item_reg;
    assign step = step_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

// ===== src/char_lcd_command_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  payload
// s_        in         one request: opcode in tuser, operands in tdata
// m_        out        one bus write per beat, tlast on the request's final write
//
// one result beat per cycle unless m_tready stalls; a request gives 1 to 10 beats (init 8, glyph 10, others 1)
// set by the step counter walking the held request through the expander
// a new request is taken in the cycle the previous one's final beat moves to the output
// aresetn (sync, active low) clears the hold and output valid flags
// m_tready low stalls the output register and, through it, the step counter

module char_lcd_command_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // column[5:0], row[7:6], char_code[15:8],
                                   // glyph_index[19:16], glyph_bitmap[59:20], zero pad
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // bus_byte[7:0], wait_before_ms[11:8],
                                   // wait_after_ms[14:12], zero pad
    output logic [1:0]  m_tuser,   // reg_select[0], write_valid[1]
    output logic        m_tlast    // last
);
    import lcdseq_pkg::*;

    item_t             s_item;
    item_t             item;
    logic [STEP_W-1:0] step;
    logic              busy;
    logic              advance;
    result_t           gen_res;
    result_t           out_reg;
    logic              m_valid_reg, m_valid_next;

    always_comb begin
        s_item.opcode       = s_tuser;
        s_item.column       = s_tdata[5:0];
        s_item.row          = s_tdata[7:6];
        s_item.char_code    = s_tdata[15:8];
        s_item.glyph_index  = s_tdata[19:16];
        s_item.glyph_bitmap = s_tdata[59:20];
    end

    assign advance = busy && (!m_valid_reg || m_tready);

    lcdseq_item_stage u_item_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_item    (s_item),
        .advance   (advance),
        .step_last (gen_res.last),
        .item      (item),
        .step      (step),
        .busy      (busy)
    );

    lcdseq_expand u_expand (
        .item (item),
        .step (step),
        .res  (gen_res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= gen_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_reg.wait_after_ms, out_reg.wait_before_ms, out_reg.bus_byte};
    assign m_tuser  = {out_reg.write_valid, out_reg.reg_select};
    assign m_tlast  = out_reg.last;

`include "char_lcd_command_sequencer_assert.svh"

    `LCDSEQ_ASSERT_IMPLIES(a_step_range, aclk, aresetn, 1'b1, step <= GLYPH_LAST_STEP, "step counter out of range")
    `LCDSEQ_ASSERT_IMPLIES(a_reject_clean, aclk, aresetn, m_tvalid && !m_tuser[1], m_tlast && m_tdata == 16'd0 && !m_tuser[0], "rejected beat not clean")
    `LCDSEQ_ASSERT_IMPLIES(a_no_take_mid_request, aclk, aresetn, busy && !gen_res.last, !s_tready, "new request taken mid sequence")
    `LCDSEQ_ASSERT_NEXT(a_request_continues, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a request")

endmodule

`default_nettype wire

// ===== sim/char_lcd_command_sequencer_tb.sv =====
`timescale 1ns / 1ps

module char_lcd_command_sequencer_tb;
    import lcdseq_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 30;
    localparam int PHASE_ITEMS   = 120;
    localparam int NUM_PHASES    = 4;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam logic [3:0] SLOT_TOP        = 4'd15;

    class lcd_write_scoreboard;
        result_t pending_writes[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        function void push_write(logic rs, logic [7:0] bus, logic [3:0] wb, logic [2:0] wa,
                                 logic valid, logic fin);
            result_t w;
            w.reg_select     = rs;
            w.bus_byte       = bus;
            w.wait_before_ms = wb;
            w.wait_after_ms  = wa;
            w.write_valid    = valid;
            w.last           = fin;
            pending_writes.push_back(w);
        endfunction

        // expands one accepted request into the bus writes it should produce
        function void note_request(item_t req);
            logic [7:0] bus;
            case (req.opcode)
                OP_INIT: begin
                    for (int i = 0; i < INIT_LEN; i++) begin
                        if (i < 4)
                            bus = CMD_FUNCTION_SET;
                        else if (i == 4)
                            bus = CMD_DISPLAY_OFF;
                        else if (i == 5)
                            bus = CMD_CLEAR;
                        else if (i == 6)
                            bus = CMD_ENTRY_MODE;
                        else
                            bus = CMD_DISPLAY_ON;
                        push_write(RS_COMMAND, bus, (i == 0) ? 4'd15 : 4'd0,
                                   (i == 0) ? 3'd5 : ((i == 5) ? 3'd2 : 3'd1),
                                   1'b1, i == INIT_LEN - 1);
                    end
                end
                OP_CLEAR: push_write(RS_COMMAND, CMD_CLEAR, 4'd0, 3'd2, 1'b1, 1'b1);
                OP_SET_CURSOR: begin
                    if (req.row == ROW_LINE1)
                        push_write(RS_COMMAND, CMD_LINE1_BASE + 8'(req.column), 4'd0, 3'd0,
                                   1'b1, 1'b1);
                    else if (req.row == ROW_LINE2)
                        push_write(RS_COMMAND, CMD_LINE2_BASE + 8'(req.column), 4'd0, 3'd0,
                                   1'b1, 1'b1);
                    else
                        push_write(RS_COMMAND, 8'd0, 4'd0, 3'd0, 1'b0, 1'b1);
                end
                OP_WRITE_DATA: push_write(RS_DATA, req.char_code, 4'd0, 3'd0, 1'b1, 1'b1);
                OP_LOAD_GLYPH: begin
                    if (req.glyph_index >= GLYPH_SLOTS) begin
                        push_write(RS_COMMAND, 8'd0, 4'd0, 3'd0, 1'b0, 1'b1);
                    end else begin
                        push_write(RS_COMMAND,
                                   CMD_CGRAM_BASE | {2'b00, req.glyph_index[2:0], 3'b0},
                                   4'd0, 3'd0, 1'b1, 1'b0);
                        for (int i = 0; i < GLYPH_ROWS; i++)
                            push_write(RS_DATA, 8'(req.glyph_bitmap[PIXEL_W*i +: PIXEL_W]),
                                       4'd0, 3'd0, 1'b1, 1'b0);
                        push_write(RS_COMMAND, CMD_LINE1_BASE, 4'd0, 3'd0, 1'b1, 1'b1);
                    end
                end
                default: push_write(RS_COMMAND, 8'd0, 4'd0, 3'd0, 1'b0, 1'b1);
            endcase
        endfunction

        function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val) begin
                $error("%s expected 0x%0h actual 0x%0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_write(result_t got);
            result_t exp_w;
            if (pending_writes.size() == 0) begin
                $error("bus write with nothing pending: byte 0x%0h", got.bus_byte);
                errors++;
                return;
            end
            exp_w = pending_writes.pop_front();
            compare_field("reg_select", exp_w.reg_select, got.reg_select);
            compare_field("bus_byte", exp_w.bus_byte, got.bus_byte);
            compare_field("wait_before_ms", exp_w.wait_before_ms, got.wait_before_ms);
            compare_field("wait_after_ms", exp_w.wait_after_ms, got.wait_after_ms);
            compare_field("write_valid", exp_w.write_valid, got.write_valid);
            compare_field("last", exp_w.last, got.last);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;

    lcd_write_scoreboard lcd_writes = new();

    char_lcd_command_sequencer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.reg_select     = m_tuser[0];
            got.write_valid    = m_tuser[1];
            got.bus_byte       = m_tdata[7:0];
            got.wait_before_ms = m_tdata[11:8];
            got.wait_after_ms  = m_tdata[14:12];
            got.last           = m_tlast;
            lcd_writes.check_write(got);
        end
    end

    function automatic item_t make_request(logic [2:0] op, logic [5:0] col, logic [1:0] row,
                                           logic [7:0] code, logic [3:0] slot,
                                           logic [39:0] bitmap);
        item_t req;
        req.opcode       = op;
        req.column       = col;
        req.row          = row;
        req.char_code    = code;
        req.glyph_index  = slot;
        req.glyph_bitmap = bitmap;
        return req;
    endfunction

    // mostly well-formed requests with random operands, some rejected or junk ones
    function automatic item_t random_request();
        item_t       req;
        int unsigned pick;
        req = make_request(3'($urandom_range(0, 7)), 6'($urandom), 2'($urandom), 8'($urandom),
                           4'($urandom), {8'($urandom), 32'($urandom)});
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            case ($urandom_range(0, 4))
                0: req.opcode = OP_INIT;
                1: req.opcode = OP_CLEAR;
                2: req.opcode = OP_SET_CURSOR;
                3: req.opcode = OP_WRITE_DATA;
                default: req.opcode = OP_LOAD_GLYPH;
            endcase
            if (pick < 75) begin
                req.row         = $urandom_range(0, 1) ? ROW_LINE1 : ROW_LINE2;
                req.glyph_index = 4'($urandom_range(0, GLYPH_SLOTS - 1));
            end
        end
        return req;
    endfunction

    task automatic send_request(input item_t req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.opcode;
        s_tdata  <= {4'b0, req.glyph_bitmap, req.glyph_index, req.char_code, req.row,
                     req.column};
        do @(posedge aclk); while (!s_tready);
        lcd_writes.note_request(req);
    endtask

    task automatic wait_all_written();
        s_tvalid <= 1'b0;
        while (lcd_writes.pending_writes.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_INIT;
        m_tready <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // edges of every field, each operation and the rejected cases
        send_request(make_request(OP_INIT, '1, '1, '1, '1, '1));
        send_request(make_request(OP_CLEAR, '1, '0, '1, '1, '1));
        send_request(make_request(OP_SET_CURSOR, '0, ROW_LINE1, '0, '0, '0));
        send_request(make_request(OP_SET_CURSOR, '1, ROW_LINE1, '1, '1, '1));
        send_request(make_request(OP_SET_CURSOR, '0, ROW_LINE2, '0, '0, '0));
        send_request(make_request(OP_SET_CURSOR, '1, ROW_LINE2, '1, '1, '1));
        send_request(make_request(OP_SET_CURSOR, 6'd5, '0, '0, '0, '0));
        send_request(make_request(OP_SET_CURSOR, '1, '1, '1, '1, '1));
        send_request(make_request(OP_WRITE_DATA, '0, '0, '0, '0, '0));
        send_request(make_request(OP_WRITE_DATA, '1, '1, '1, '1, '1));
        send_request(make_request(OP_LOAD_GLYPH, '0, '0, '0, '0, '0));
        send_request(make_request(OP_LOAD_GLYPH, '1, '1, '1, 4'(GLYPH_SLOTS - 1), '1));
        send_request(make_request(OP_LOAD_GLYPH, '0, '0, '0, 4'(GLYPH_SLOTS - 1),
                                  40'h55555_AAAAA));
        send_request(make_request(OP_LOAD_GLYPH, '0, '0, '0, 4'(GLYPH_SLOTS), '1));
        send_request(make_request(OP_LOAD_GLYPH, '1, '1, '1, SLOT_TOP, '1));
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            send_request(make_request(3'(op), '1, '1, '1, '1, '1));
        send_request(make_request(OP_INIT, '0, '0, '0, '0, '0));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_all_written();
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 46;
                end
                default: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
        end

        wait_all_written();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (lcd_writes.pending_writes.size() != 0) begin
            $error("%0d bus writes never arrived", lcd_writes.pending_writes.size());
            lcd_writes.errors++;
        end
        if (lcd_writes.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
